FILE: design/rmte_pkg.sv
// Package for the rotation-matrix to Euler-angle pipeline.
// Holds widths, constants, the CORDIC angle table and the output rounding.
// Used by rmte_sqrt, rmte_cordic and rotation_matrix_to_euler_angles_top.
package rmte_pkg;

  localparam int MAT_W          = 16;
  localparam int THR_W          = 15;
  localparam int SUM_W          = 32;
  localparam int SY_W           = 16;
  localparam int SQRT_STEPS     = 16;
  localparam int OP_W           = 17;
  localparam int XY_W           = 34;
  localparam int Z_W            = 26;
  localparam int ANG_W          = 17;
  localparam int ROLL_W         = 16;
  localparam int PITCH_W        = 15;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES     = 24;

  localparam logic [THR_W-1:0]      THR_RESET = THR_W'(1);
  localparam logic signed [Z_W-1:0] Z_180     = Z_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] ROLL_LIM  = ANG_W'(23040);
  localparam logic signed [ANG_W-1:0] PITCH_LIM = ANG_W'(11520);

  typedef struct packed {
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
  } side_t;

  // round(atan(2^-i) * 180/pi * 2^16)
  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up to 7 fractional bits, then clamp to +/- lim.
  function automatic logic signed [ANG_W-1:0] rnd_sat(input logic signed [Z_W-1:0] z,
                                                      input logic signed [ANG_W-1:0] lim);
    logic signed [Z_W-1:0] t;
    logic signed [Z_W-1:0] l;
    t = (z + Z_W'(256)) >>> 9;
    l = Z_W'(lim);
    if (t > l) t = l;
    if (t < -l) t = -l;
    return ANG_W'(t);
  endfunction

endpackage

FILE: design/rmte_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
// Depends on rmte_pkg.
module rmte_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [rmte_pkg::SUM_W-1:0] in_sq0,
  input  logic [rmte_pkg::SUM_W-1:0] in_sq1,
  input  rmte_pkg::side_t        in_side,
  output logic                   out_valid,
  output logic [rmte_pkg::SY_W-1:0] out_sy,
  output rmte_pkg::side_t        out_side
);
  import rmte_pkg::*;

  logic [SUM_W-1:0] rem_r  [0:SQRT_STEPS];
  logic [SUM_W-1:0] root_r [0:SQRT_STEPS];
  side_t            side_r [0:SQRT_STEPS];
  logic             vld_r  [0:SQRT_STEPS];

  // Stage 0: form the sum of squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_sq0 + in_sq1;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] rem_nxt;
    logic [SUM_W-1:0] root_nxt;

    always_comb begin
      trial = root_r[k] + BIT;
      if (rem_r[k] >= trial) begin
        rem_nxt  = rem_r[k] - trial;
        root_nxt = (root_r[k] >> 1) + BIT;
      end else begin
        rem_nxt  = rem_r[k];
        root_nxt = root_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS];
  assign out_sy    = root_r[SQRT_STEPS][SY_W-1:0];
  assign out_side  = side_r[SQRT_STEPS];

endmodule

FILE: design/rmte_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees, 16 fractional bits.
// Depends on rmte_pkg for widths and the angle table.
module rmte_cordic #(
  parameter int STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rmte_pkg::OP_W-1:0] in_x,
  input  logic signed [rmte_pkg::OP_W-1:0] in_y,
  output logic signed [rmte_pkg::Z_W-1:0]  out_z
);
  import rmte_pkg::*;

  logic signed [XY_W-1:0] x_r [0:STAGES];
  logic signed [XY_W-1:0] y_r [0:STAGES];
  logic signed [Z_W-1:0]  z_r [0:STAGES];

  logic signed [XY_W-1:0] xe, ye;
  logic signed [XY_W-1:0] x0_nxt, y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;

  // Fold the left half-plane over, then scale to the working precision.
  always_comb begin
    xe = XY_W'(in_x);
    ye = XY_W'(in_y);
    if (in_x < 0) begin
      x0_nxt = (-xe) <<< 14;
      y0_nxt = (-ye) <<< 14;
      z0_nxt = (in_y >= 0) ? Z_180 : -Z_180;
    end else begin
      x0_nxt = xe <<< 14;
      y0_nxt = ye <<< 14;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= z0_nxt;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ANG = (i < MAX_STAGES) ? atan_q16(i) : '0;
    logic signed [XY_W-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (y_r[i] > 0) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + ANG;
      end else if (y_r[i] < 0) begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - ANG;
      end else begin
        x_nxt = x_r[i];
        y_nxt = y_r[i];
        z_nxt = z_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign out_z = z_r[STAGES];

endmodule

FILE: design/rotation_matrix_to_euler_angles_top.sv
// Top level: rotation matrix (Z-Y-X) to roll, pitch and yaw in degrees.
// Depends on rmte_pkg, rmte_sqrt and rmte_cordic.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_m00 in_m10 in_m20 in_m21 in_m22 in_m11 in_m12
// out_      output     out_valid/out_stall  out_roll_deg out_pitch_deg out_yaw_deg out_singular
// cfg_      input      cfg_we               cfg_wdata (singular threshold)
//
// One item enters per cycle while the output is not stalled; the stages are squares,
// sum and square root, CORDIC fold, CORDIC iterations and rounding.
// The square-root chain and the CORDIC iteration chain are the long parts of the pipeline.
// Reset clears the valid bits and loads the threshold with 1.
// A stall on the output while out_valid is high freezes every stage at once; in_stall follows it.
module rotation_matrix_to_euler_angles_top #(
  parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m00,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m10,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m20,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m21,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m22,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m11,
  input  logic signed [rmte_pkg::MAT_W-1:0] in_m12,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [rmte_pkg::ROLL_W-1:0]  out_roll_deg,
  output logic signed [rmte_pkg::PITCH_W-1:0] out_pitch_deg,
  output logic signed [rmte_pkg::ROLL_W-1:0]  out_yaw_deg,
  output logic out_singular,
  input  logic cfg_we,
  input  logic [rmte_pkg::THR_W-1:0] cfg_wdata
);
  import rmte_pkg::*;

  logic en;
  logic [THR_W-1:0] thr_r;

  // Stage A: squares.
  logic             va_r;
  logic [SUM_W-1:0] sq00_r, sq10_r;
  side_t            side_a_r;
  side_t            side_in;
  logic signed [2*MAT_W-1:0] p00, p10;

  // Square-root outputs.
  logic             vs;
  logic [SY_W-1:0]  sy;
  side_t            side_s;

  // Operand selection.
  logic             sing;
  logic signed [OP_W-1:0] roll_x, roll_y, pitch_x, pitch_y, yaw_x, yaw_y;

  // Valid and flag line beside the CORDIC lanes.
  logic vld_line_r  [0:CORDIC_STAGES];
  logic sing_line_r [0:CORDIC_STAGES];

  logic signed [Z_W-1:0] roll_z, pitch_z, yaw_z;
  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;

  logic out_valid_r, out_singular_r;
  logic signed [ROLL_W-1:0]  out_roll_r, out_yaw_r;
  logic signed [PITCH_W-1:0] out_pitch_r;

  // Advance the whole pipeline unless a finished item is held at the output.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_comb begin
    side_in.m00 = in_m00;
    side_in.m10 = in_m10;
    side_in.m20 = in_m20;
    side_in.m21 = in_m21;
    side_in.m22 = in_m22;
    side_in.m11 = in_m11;
    side_in.m12 = in_m12;
    p00 = in_m00 * in_m00;
    p10 = in_m10 * in_m10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq00_r   <= SUM_W'(unsigned'(p00));
      sq10_r   <= SUM_W'(unsigned'(p10));
      side_a_r <= side_in;
    end
  end

  rmte_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (va_r),
    .in_sq0    (sq00_r),
    .in_sq1    (sq10_r),
    .in_side   (side_a_r),
    .out_valid (vs),
    .out_sy    (sy),
    .out_side  (side_s)
  );

  // Pick roll operands by gimbal lock; user must move the threshold only while idle, unchecked.
  always_comb begin
    sing    = {1'b0, sy} < {2'b00, thr_r};
    if (sing) begin
      roll_x = OP_W'(side_s.m11);
      roll_y = -OP_W'(side_s.m12);
    end else begin
      roll_x = OP_W'(side_s.m22);
      roll_y = OP_W'(side_s.m21);
    end
    pitch_x = OP_W'({1'b0, sy});
    pitch_y = -OP_W'(side_s.m20);
    yaw_x   = OP_W'(side_s.m00);
    yaw_y   = OP_W'(side_s.m10);
  end

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .en (en), .in_x (roll_x), .in_y (roll_y), .out_z (roll_z)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .en (en), .in_x (pitch_x), .in_y (pitch_y), .out_z (pitch_z)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .en (en), .in_x (yaw_x), .in_y (yaw_y), .out_z (yaw_z)
  );

  // Carry valid and the singular flag alongside the CORDIC stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_line_r[0] <= 1'b0;
    end else if (en) begin
      vld_line_r[0] <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_line_r[0] <= sing;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_line_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_line_r[i+1] <= vld_line_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sing_line_r[i+1] <= sing_line_r[i];
      end
    end
  end

  // Round, clamp and drop yaw in gimbal lock.
  always_comb begin
    roll_a  = rnd_sat(roll_z, ROLL_LIM);
    pitch_a = rnd_sat(pitch_z, PITCH_LIM);
    yaw_a   = sing_line_r[CORDIC_STAGES] ? '0 : rnd_sat(yaw_z, ROLL_LIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_line_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_r     <= roll_a[ROLL_W-1:0];
      out_pitch_r    <= pitch_a[PITCH_W-1:0];
      out_yaw_r      <= yaw_a[ROLL_W-1:0];
      out_singular_r <= sing_line_r[CORDIC_STAGES];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_roll_deg  = out_roll_r;
  assign out_pitch_deg = out_pitch_r;
  assign out_yaw_deg   = out_yaw_r;
  assign out_singular  = out_singular_r;

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

  a_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_yaw_deg == '0))
    else $error("yaw not zero in gimbal lock");

  a_pitch_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch_deg <= PITCH_W'(11520)) && (out_pitch_deg >= -PITCH_W'(11520))))
    else $error("pitch outside clamp");

  a_roll_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_roll_deg <= ROLL_W'(23040)) && (out_roll_deg >= -ROLL_W'(23040))))
    else $error("roll outside clamp");

endmodule
